/* rtl/wmc_pkg.sv */
// Shared constants and state type for the sliding-window mean/covariance block.
// Depends on nothing; used by the top level, the window memory users and the checker.
`timescale 1ns / 1ps
`default_nettype none
package wmc_pkg;
    localparam int W      = 32;              // coordinate width, Q16.16
    localparam int NMAX   = 32;              // window depth
    localparam int AW     = $clog2(NMAX);    // window address width
    localparam int CW     = $clog2(NMAX) + 1; // fill count width
    localparam int SUMW   = W + CW;          // exact coordinate sum
    localparam int DEVW   = W + 1;           // deviation from mean
    localparam int PRODW  = 2 * DEVW;        // deviation product
    localparam int ACW    = PRODW + CW - 1;  // exact product sum
    localparam int DVW    = ACW + 1;         // divider dividend / quotient
    localparam int DSW    = CW + 16;         // divider divisor (n << 16)
    localparam int DCW    = $clog2(DVW + 1); // divider step counter
    localparam int NRES   = 9;
    localparam int NPAIR  = 6;

    localparam logic [1:0] REG_WLEN   = 2'd0;
    localparam logic [1:0] REG_SEED_X = 2'd1;
    localparam logic [1:0] REG_SEED_Y = 2'd2;
    localparam logic [1:0] REG_SEED_Z = 2'd3;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_DROP   = 13'b0000000000010,
        ST_WRITE  = 13'b0000000000100,
        ST_FETCH  = 13'b0000000001000,
        ST_SUM    = 13'b0000000010000,
        ST_DLOAD  = 13'b0000000100000,
        ST_DIV    = 13'b0000001000000,
        ST_DDONE  = 13'b0000010000000,
        ST_FETCH2 = 13'b0000100000000,
        ST_DEV    = 13'b0001000000000,
        ST_MUL    = 13'b0010000000000,
        ST_MACC   = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } t_state;
endpackage
`default_nettype wire

/* rtl/wmc_mem.sv */
// Generic single-port-write, registered-read memory.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wmc_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/window_mean_covariance_3d.sv */
// Each item runs through the 72-step one-bit divider, nine times over, and the single
// shared multiplier, six products per window entry (up to 32 entries). One item at a
// time; the result waits in an output register, so the next item is taken while it is
// still unread.
// Reset (synchronous, active low): window holds only the seed, length 30, seed at zero.
`timescale 1ns / 1ps
`default_nettype none
module window_mean_covariance_3d (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [95:0] s_axis_tdata,   // loc_x, loc_y, loc_z
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [287:0] m_axis_tdata,  // mean_x/y/z, cov_xx, xy, xz, yy, yz, zz
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);
    wmc_pkg::t_state r_state;

    logic [wmc_pkg::CW-1:0]   r_wlen;
    logic signed [wmc_pkg::W-1:0] r_seed_x, r_seed_y, r_seed_z;
    logic [wmc_pkg::AW-1:0]   r_oldest;
    logic [wmc_pkg::CW-1:0]   r_fill;
    logic                     r_seed_in;
    logic [95:0]              r_loc;
    logic [wmc_pkg::CW-1:0]   r_idx;
    logic [3:0]               r_sel;
    logic [2:0]               r_pair;
    logic [wmc_pkg::DCW-1:0]  r_cnt;
    logic signed [wmc_pkg::SUMW-1:0] r_sum [3];
    logic signed [wmc_pkg::ACW-1:0]  r_acc [wmc_pkg::NPAIR];
    logic signed [wmc_pkg::DEVW-1:0] r_dx, r_dy, r_dz;
    logic signed [wmc_pkg::PRODW-1:0] r_prod;
    logic [wmc_pkg::DVW-1:0]  r_dvd;
    logic [wmc_pkg::DSW-1:0]  r_dsr;
    logic [wmc_pkg::DSW-1:0]  r_rem;
    logic                     r_neg;
    logic [wmc_pkg::W-1:0]    r_res [wmc_pkg::NRES];
    logic                     r_m_valid;
    logic [287:0]             r_m_data;

    // window length clamped to 1..NMAX, minus one
    logic [wmc_pkg::CW-1:0] len_m1;
    always_comb begin
        if (r_wlen == '0) begin
            len_m1 = '0;
        end else if (r_wlen > wmc_pkg::CW'(wmc_pkg::NMAX)) begin
            len_m1 = wmc_pkg::CW'(wmc_pkg::NMAX - 1);
        end else begin
            len_m1 = r_wlen - 1'b1;
        end
    end

    logic [wmc_pkg::CW-1:0] drops;
    logic [wmc_pkg::CW-1:0] stored;
    assign drops  = r_fill - len_m1;
    assign stored = r_fill - wmc_pkg::CW'(r_seed_in);

    // window memory: x, y, z packed
    logic                   mem_we;
    logic [wmc_pkg::AW-1:0] mem_waddr, mem_raddr;
    logic [95:0]            mem_rdata;
    assign mem_we    = (r_state == wmc_pkg::ST_WRITE);
    assign mem_waddr = r_oldest + stored[wmc_pkg::AW-1:0];
    assign mem_raddr = r_oldest + r_idx[wmc_pkg::AW-1:0] - wmc_pkg::AW'(r_seed_in);

    wmc_mem #(.WIDTH(96), .DEPTH(wmc_pkg::NMAX)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_loc),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // current window entry: seed first while it is present
    logic use_seed;
    logic signed [wmc_pkg::W-1:0] e_x, e_y, e_z;
    assign use_seed = r_seed_in && (r_idx == '0);
    assign e_x = use_seed ? r_seed_x : mem_rdata[31:0];
    assign e_y = use_seed ? r_seed_y : mem_rdata[63:32];
    assign e_z = use_seed ? r_seed_z : mem_rdata[95:64];

    logic last_entry;
    assign last_entry = (r_idx == r_fill - 1'b1);

    // shared multiplier operands
    logic signed [wmc_pkg::DEVW-1:0] op_a, op_b;
    always_comb begin
        case (r_pair)
            3'd0:    begin op_a = r_dx; op_b = r_dx; end
            3'd1:    begin op_a = r_dx; op_b = r_dy; end
            3'd2:    begin op_a = r_dx; op_b = r_dz; end
            3'd3:    begin op_a = r_dy; op_b = r_dy; end
            3'd4:    begin op_a = r_dy; op_b = r_dz; end
            default: begin op_a = r_dz; op_b = r_dz; end
        endcase
    end

    // divider operands
    logic signed [wmc_pkg::SUMW-1:0] sum_sel;
    logic signed [wmc_pkg::ACW-1:0]  acc_sel;
    logic [wmc_pkg::SUMW-1:0] sum_mag;
    logic [wmc_pkg::ACW-1:0]  acc_mag;
    logic [2:0]               acc_i;
    logic                     is_mean;
    assign is_mean = (r_sel < 4'd3);
    assign acc_i   = 3'(r_sel - 4'd3);
    assign sum_sel = r_sum[r_sel[1:0] == 2'd3 ? 2'd0 : r_sel[1:0]];
    assign acc_sel = r_acc[acc_i > 3'd5 ? 3'd0 : acc_i];
    assign sum_mag = sum_sel[wmc_pkg::SUMW-1] ? wmc_pkg::SUMW'(-sum_sel)
                                              : wmc_pkg::SUMW'(sum_sel);
    assign acc_mag = acc_sel[wmc_pkg::ACW-1] ? wmc_pkg::ACW'(-acc_sel)
                                             : wmc_pkg::ACW'(acc_sel);

    logic [wmc_pkg::DSW:0] trial;
    assign trial = {r_rem, r_dvd[wmc_pkg::DVW-1]} - {1'b0, r_dsr};

    // rounded quotient to Q16.16 result
    logic [wmc_pkg::W-1:0] q_res;
    always_comb begin
        if (is_mean) begin
            q_res = r_neg ? -r_dvd[31:0] : r_dvd[31:0];
        end else if (r_neg) begin
            if ((|r_dvd[wmc_pkg::DVW-1:32]) || (r_dvd[31] && (|r_dvd[30:0]))) begin
                q_res = 32'h8000_0000;
            end else begin
                q_res = -r_dvd[31:0];
            end
        end else if (|r_dvd[wmc_pkg::DVW-1:31]) begin
            q_res = 32'h7FFF_FFFF;
        end else begin
            q_res = r_dvd[31:0];
        end
    end

    logic out_free;
    assign out_free = !r_m_valid || m_axis_tready;

    assign s_axis_tready = (r_state == wmc_pkg::ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen   <= wmc_pkg::CW'(30);
            r_seed_x <= '0;
            r_seed_y <= '0;
            r_seed_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wmc_pkg::REG_WLEN:   r_wlen   <= i_cfg_data[wmc_pkg::CW-1:0];
                wmc_pkg::REG_SEED_X: r_seed_x <= i_cfg_data;
                wmc_pkg::REG_SEED_Y: r_seed_y <= i_cfg_data;
                wmc_pkg::REG_SEED_Z: r_seed_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == wmc_pkg::ST_OUT && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (r_state == wmc_pkg::ST_OUT && out_free) begin
            r_m_data <= {r_res[8], r_res[7], r_res[6], r_res[5], r_res[4],
                         r_res[3], r_res[2], r_res[1], r_res[0]};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wmc_pkg::ST_IDLE;
            r_oldest  <= '0;
            r_fill    <= wmc_pkg::CW'(1);
            r_seed_in <= 1'b1;
        end else begin
            unique case (r_state)
                wmc_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_loc   <= s_axis_tdata;
                        r_state <= wmc_pkg::ST_DROP;
                    end
                end
                wmc_pkg::ST_DROP: begin
                    // drop oldest entries, seed first
                    if (r_fill > len_m1) begin
                        r_fill <= len_m1;
                        if (r_seed_in) begin
                            r_seed_in <= 1'b0;
                            r_oldest  <= r_oldest + wmc_pkg::AW'(drops - 1'b1);
                        end else begin
                            r_oldest  <= r_oldest + drops[wmc_pkg::AW-1:0];
                        end
                    end
                    r_state <= wmc_pkg::ST_WRITE;
                end
                wmc_pkg::ST_WRITE: begin
                    r_fill  <= r_fill + 1'b1;
                    r_idx   <= '0;
                    r_sum[0] <= '0;
                    r_sum[1] <= '0;
                    r_sum[2] <= '0;
                    r_state <= wmc_pkg::ST_FETCH;
                end
                wmc_pkg::ST_FETCH: begin
                    r_state <= wmc_pkg::ST_SUM;
                end
                wmc_pkg::ST_SUM: begin
                    r_sum[0] <= r_sum[0] + wmc_pkg::SUMW'(e_x);
                    r_sum[1] <= r_sum[1] + wmc_pkg::SUMW'(e_y);
                    r_sum[2] <= r_sum[2] + wmc_pkg::SUMW'(e_z);
                    r_idx    <= r_idx + 1'b1;
                    if (last_entry) begin
                        r_sel   <= '0;
                        r_state <= wmc_pkg::ST_DLOAD;
                    end else begin
                        r_state <= wmc_pkg::ST_FETCH;
                    end
                end
                wmc_pkg::ST_DLOAD: begin
                    r_rem <= '0;
                    r_cnt <= '0;
                    if (is_mean) begin
                        r_neg <= sum_sel[wmc_pkg::SUMW-1];
                        r_dvd <= wmc_pkg::DVW'(sum_mag) + wmc_pkg::DVW'(r_fill >> 1);
                        r_dsr <= wmc_pkg::DSW'(r_fill);
                    end else begin
                        r_neg <= acc_sel[wmc_pkg::ACW-1];
                        r_dvd <= wmc_pkg::DVW'(acc_mag) + (wmc_pkg::DVW'(r_fill) << 15);
                        r_dsr <= wmc_pkg::DSW'(r_fill) << 16;
                    end
                    r_state <= wmc_pkg::ST_DIV;
                end
                wmc_pkg::ST_DIV: begin
                    // one restoring step per cycle
                    if (!trial[wmc_pkg::DSW]) begin
                        r_rem <= trial[wmc_pkg::DSW-1:0];
                    end else begin
                        r_rem <= {r_rem[wmc_pkg::DSW-2:0], r_dvd[wmc_pkg::DVW-1]};
                    end
                    r_dvd <= {r_dvd[wmc_pkg::DVW-2:0], !trial[wmc_pkg::DSW]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == wmc_pkg::DCW'(wmc_pkg::DVW - 1)) begin
                        r_state <= wmc_pkg::ST_DDONE;
                    end
                end
                wmc_pkg::ST_DDONE: begin
                    r_res[r_sel] <= q_res;
                    r_sel <= r_sel + 1'b1;
                    if (r_sel == 4'd2) begin
                        r_idx <= '0;
                        for (int k = 0; k < wmc_pkg::NPAIR; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_state <= wmc_pkg::ST_FETCH2;
                    end else if (r_sel == 4'(wmc_pkg::NRES - 1)) begin
                        r_state <= wmc_pkg::ST_OUT;
                    end else begin
                        r_state <= wmc_pkg::ST_DLOAD;
                    end
                end
                wmc_pkg::ST_FETCH2: begin
                    r_state <= wmc_pkg::ST_DEV;
                end
                wmc_pkg::ST_DEV: begin
                    r_dx   <= wmc_pkg::DEVW'(e_x) - wmc_pkg::DEVW'($signed(r_res[0]));
                    r_dy   <= wmc_pkg::DEVW'(e_y) - wmc_pkg::DEVW'($signed(r_res[1]));
                    r_dz   <= wmc_pkg::DEVW'(e_z) - wmc_pkg::DEVW'($signed(r_res[2]));
                    r_pair <= '0;
                    r_state <= wmc_pkg::ST_MUL;
                end
                wmc_pkg::ST_MUL: begin
                    r_prod  <= op_a * op_b;
                    r_state <= wmc_pkg::ST_MACC;
                end
                wmc_pkg::ST_MACC: begin
                    r_acc[r_pair] <= r_acc[r_pair] + wmc_pkg::ACW'(r_prod);
                    r_pair <= r_pair + 1'b1;
                    if (r_pair == 3'(wmc_pkg::NPAIR - 1)) begin
                        r_idx <= r_idx + 1'b1;
                        if (last_entry) begin
                            r_state <= wmc_pkg::ST_DLOAD;
                        end else begin
                            r_state <= wmc_pkg::ST_FETCH2;
                        end
                    end else begin
                        r_state <= wmc_pkg::ST_MUL;
                    end
                end
                wmc_pkg::ST_OUT: begin
                    if (out_free) begin
                        r_state <= wmc_pkg::ST_IDLE;
                    end
                end
                default: r_state <= wmc_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/wmc_chk.sv */
// Port-level checker for the window mean/covariance block, bound to the top level.
// Depends on window_mean_covariance_3d ports only.
`timescale 1ns / 1ps
`default_nettype none
module wmc_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [287:0] m_axis_tdata
);
    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");
endmodule

bind window_mean_covariance_3d wmc_chk u_wmc_chk (.*);
`default_nettype wire

/* bench/wmc_checker.sv */
// Checker for window_mean_covariance_3d: watches the input and result streams,
// predicts window means and covariances, and counts mismatches.
// Depends on wmc_pkg for the register indexes and widths.
`timescale 1ns / 1ps
module wmc_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  wire  [95:0]  i_in_data,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  wire  [287:0] i_out_data,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_idx,
    input  wire  [31:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    logic [31:0]  pt_x [wmc_pkg::NMAX];
    logic [31:0]  pt_y [wmc_pkg::NMAX];
    logic [31:0]  pt_z [wmc_pkg::NMAX];
    int           head;
    int           fill;
    bit           seed_live;
    logic [5:0]   wlen;
    logic [31:0]  sx, sy, sz;
    // expected results in order, as a ring
    logic [287:0] exp_ring [16];
    int           wr_cnt = 0;
    int           rd_cnt = 0;

    assign o_pending = wr_cnt - rd_cnt;

    function automatic logic [31:0] round_mean(longint vals[wmc_pkg::NMAX], int n);
        longint s;
        longint q;
        s = 0;
        for (int i = 0; i < n; i++) s += vals[i];
        q = ((s < 0 ? -s : s) + n / 2) / n;
        return 32'(s < 0 ? -q : q);
    endfunction

    function automatic logic [31:0] round_cov(longint a[wmc_pkg::NMAX], longint ma,
                                              longint b[wmc_pkg::NMAX], longint mb,
                                              int n);
        logic signed [95:0] acc;
        logic signed [95:0] mg;
        logic signed [95:0] d;
        logic signed [95:0] q;
        acc = 0;
        for (int i = 0; i < n; i++)
            acc += 96'(signed'(a[i] - ma)) * 96'(signed'(b[i] - mb));
        d = 96'(n) <<< 16;
        mg = acc < 0 ? -acc : acc;
        q = (mg + (d >>> 1)) / d;
        if (acc < 0) return q > 96'sh80000000 ? 32'h80000000 : 32'(-q);
        return q > 96'sh7FFFFFFF ? 32'h7FFFFFFF : 32'(q);
    endfunction

    task automatic predict_stats(logic [95:0] loc);
        longint vx[wmc_pkg::NMAX], vy[wmc_pkg::NMAX], vz[wmc_pkg::NMAX];
        longint mx, my, mz;
        int lim, kept, n;
        logic [31:0] m0, m1, m2;
        lim = wlen < 1 ? 1 : (wlen > wmc_pkg::NMAX ? wmc_pkg::NMAX : int'(wlen));
        while (fill > 0 && fill + 1 > lim) begin
            if (seed_live) seed_live = 0;
            else head = (head + 1) % wmc_pkg::NMAX;
            fill--;
        end
        kept = fill - (seed_live ? 1 : 0);
        pt_x[(head + kept) % wmc_pkg::NMAX] = loc[31:0];
        pt_y[(head + kept) % wmc_pkg::NMAX] = loc[63:32];
        pt_z[(head + kept) % wmc_pkg::NMAX] = loc[95:64];
        fill++;
        kept++;
        n = 0;
        if (seed_live) begin
            vx[0] = signed'(sx); vy[0] = signed'(sy); vz[0] = signed'(sz);
            n = 1;
        end
        for (int i = 0; i < kept && n < wmc_pkg::NMAX; i++) begin
            vx[n] = signed'(pt_x[(head + i) % wmc_pkg::NMAX]);
            vy[n] = signed'(pt_y[(head + i) % wmc_pkg::NMAX]);
            vz[n] = signed'(pt_z[(head + i) % wmc_pkg::NMAX]);
            n++;
        end
        m0 = round_mean(vx, n);
        m1 = round_mean(vy, n);
        m2 = round_mean(vz, n);
        mx = signed'(m0); my = signed'(m1); mz = signed'(m2);
        exp_ring[wr_cnt % 16] = {round_cov(vz, mz, vz, mz, n),
                                 round_cov(vy, my, vz, mz, n),
                                 round_cov(vy, my, vy, my, n),
                                 round_cov(vx, mx, vz, mz, n),
                                 round_cov(vx, mx, vy, my, n),
                                 round_cov(vx, mx, vx, mx, n), m2, m1, m0};
        wr_cnt++;
    endtask

    always @(posedge i_clk) begin
        logic [287:0] want;
        if (!i_rst_n) begin
            head = 0; fill = 1; seed_live = 1;
            wlen = 6'd30; sx = '0; sy = '0; sz = '0;
            o_fail_count = 0;
            wr_cnt = 0; rd_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wmc_pkg::REG_WLEN:   wlen = i_cfg_data[5:0];
                    wmc_pkg::REG_SEED_X: sx = i_cfg_data;
                    wmc_pkg::REG_SEED_Y: sy = i_cfg_data;
                    wmc_pkg::REG_SEED_Z: sz = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_stats(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (wr_cnt == rd_cnt) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = exp_ring[rd_cnt % 16];
                    rd_cnt++;
                    for (int f = 0; f < wmc_pkg::NRES; f++)
                        if (want[f*32 +: 32] != i_out_data[f*32 +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, f,
                                     want[f*32 +: 32], i_out_data[f*32 +: 32]);
                            o_fail_count = o_fail_count + 1;
                        end
                end
            end
        end
    end
endmodule

/* bench/tb_window_mean_covariance_3d.sv */
// Top of the window_mean_covariance_3d bench: clock, reset, location stimulus,
// configuration phases and the verdict. Depends on wmc_pkg and wmc_checker.
`timescale 1ns / 1ps
module tb_window_mean_covariance_3d;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_valid = 0;
    wire          s_ready;
    logic [95:0]  s_data = '0;   // loc_x, loc_y, loc_z
    wire          m_valid;
    logic         m_ready = 0;
    wire  [287:0] m_data;        // mean_x/y/z, cov_xx, xy, xz, yy, yz, zz
    logic         cfg_we = 0;
    logic [1:0]   cfg_idx = wmc_pkg::REG_WLEN;
    logic [31:0]  cfg_data = '0;
    int           fail_count, pending;
    int           cycle = 0;
    bit           hold_off = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    window_mean_covariance_3d u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data));

    wmc_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending));

    // receiver: own stall pattern, plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_off) m_ready <= 0;
        else case ($urandom_range(0, 3))
            0: m_ready <= 0;
            default: m_ready <= 1;
        endcase
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 10000000) begin
            $display("FAIL window_mean_covariance_3d");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535) - 32768;
            3: return $urandom_range(0, 1) ? 32'h7FFF0000 + $urandom_range(0, 65535)
                                          : 32'h80000000 + $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_loc(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        s_valid <= 1;
        s_data <= {z, y, x};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 200)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    // drain the result queue and let the block settle before a register write
    task automatic settle();
        s_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1300) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] wl;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: seed at reset values, then extremes
        send_loc(32'h7FFFFFFF, 32'h80000000, 32'h00010000);
        send_loc(32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000);
        send_loc(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_loc(32'h80000000, 32'h80000000, 32'h80000000);
        send_loc(32'h00000001, 32'hFFFFFFFF, 32'h0);
        settle();
        // length zero: lowered length drops the seed first; then 63, then two
        write_reg(wmc_pkg::REG_SEED_X, 32'h80000000);
        write_reg(wmc_pkg::REG_SEED_Y, 32'h7FFFFFFF);
        write_reg(wmc_pkg::REG_SEED_Z, 32'h12345678);
        write_reg(wmc_pkg::REG_WLEN, 32'd0);
        send_loc(32'h00000003, 32'hFFFFFFFD, 32'h0);
        send_loc(32'h7FFFFFFF, 32'h0, 32'h80000000);
        settle();
        write_reg(wmc_pkg::REG_WLEN, 32'd63);
        for (int i = 0; i < 6; i++) send_loc(rand_coord(), rand_coord(), rand_coord());
        settle();
        write_reg(wmc_pkg::REG_WLEN, 32'd2);
        send_loc(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_loc(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        settle();
        // long hold-off while the sender keeps offering
        hold_off <= 1;
        fork
            begin
                repeat (6000) @(posedge i_clk);
                hold_off <= 0;
            end
            for (int i = 0; i < 8; i++) send_loc(rand_coord(), rand_coord(), rand_coord());
        join
        settle();
        // random phases with changing lengths: one, 32, or random in 0..63
        for (int ph = 0; ph < 26; ph++) begin
            case (ph % 4)
                0: wl = 32'd1;
                1: wl = 32'd32;
                default: wl = $urandom_range(0, 63);
            endcase
            write_reg(wmc_pkg::REG_WLEN, wl);
            write_reg(wmc_pkg::REG_SEED_X, rand_coord());
            write_reg(wmc_pkg::REG_SEED_Y, rand_coord());
            write_reg(wmc_pkg::REG_SEED_Z, rand_coord());
            for (int i = 0; i < 50; i++) send_loc(rand_coord(), rand_coord(), rand_coord());
            settle();
        end
        if (fail_count == 0)
            $display("PASS window_mean_covariance_3d");
        else
            $display("FAIL window_mean_covariance_3d");
        $finish;
    end
endmodule

/* sim.f */
rtl/wmc_pkg.sv
rtl/wmc_mem.sv
rtl/window_mean_covariance_3d.sv
rtl/wmc_chk.sv
bench/wmc_checker.sv
bench/tb_window_mean_covariance_3d.sv
